// ===== sv/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// drt_pkg: shared definitions for the dirty rectangle tracker
// Action codes, register indexes, field widths and the result word type.
// ----------------------------------------------------------------------------
package drt_pkg;

  // Default signed coordinate width of the input positions.
  localparam int unsigned CoordBitsDef = 16;

  // Fixed field widths.
  localparam int unsigned ScreenDimW = 14;
  localparam int unsigned RectDimW   = 15;
  localparam int unsigned OutCoordW  = 13;
  localparam int unsigned CfgIdxW    = 2;

  // Screen sizes above this value behave as this value.
  localparam logic [ScreenDimW-1:0] MaxScreen = 14'd8192;

  // Screen size after reset.
  localparam logic [ScreenDimW-1:0] DefWidth  = 14'd1024;
  localparam logic [ScreenDimW-1:0] DefHeight = 14'd768;

  typedef enum logic [2:0] {
    ACT_MARK_PIXEL   = 3'd0,
    ACT_MARK_RECT    = 3'd1,
    ACT_MARK_CLAMPED = 3'd2,
    ACT_MARK_FULL    = 3'd3,
    ACT_FLUSH        = 3'd4
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_e;

  // One flush report.
  typedef struct packed {
    logic                 region_valid;
    logic [OutCoordW-1:0] left;
    logic [OutCoordW-1:0] top;
    logic [OutCoordW-1:0] right;
    logic [OutCoordW-1:0] bottom;
  } drt_region_t;

endpackage

// ===== sv/drt_box.sv =====
// ----------------------------------------------------------------------------
// drt_box: bounding box state and per-word evaluation
// Grows the box on marks, clips and reports it on a flush.
// ----------------------------------------------------------------------------
module drt_box #(
  parameter int unsigned COORD_BITS = drt_pkg::CoordBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  fire_i,
  input  logic [2:0]                            action_i,
  input  logic signed [COORD_BITS-1:0]          pos_x_i,
  input  logic signed [COORD_BITS-1:0]          pos_y_i,
  input  logic [drt_pkg::RectDimW-1:0]          rect_w_i,
  input  logic [drt_pkg::RectDimW-1:0]          rect_h_i,
  input  logic [drt_pkg::ScreenDimW-1:0]        screen_width_i,
  input  logic [drt_pkg::ScreenDimW-1:0]        screen_height_i,
  output logic                                  has_result_o,
  output drt_pkg::drt_region_t                  result_o
);

  // Room for a coordinate plus a rectangle size, and for the screen size.
  localparam int unsigned BoxW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
  localparam int unsigned OW   = drt_pkg::OutCoordW;

  localparam logic signed [BoxW-1:0] SOne  = BoxW'(1);
  localparam logic signed [BoxW-1:0] SZero = BoxW'(0);
  localparam logic signed [BoxW-1:0] RstMaxX =
    $signed(BoxW'(drt_pkg::DefWidth)) - SOne;
  localparam logic signed [BoxW-1:0] RstMaxY =
    $signed(BoxW'(drt_pkg::DefHeight)) - SOne;

  logic signed [BoxW-1:0] min_x_q, min_x_d, min_y_q, min_y_d;
  logic signed [BoxW-1:0] max_x_q, max_x_d, max_y_q, max_y_d;
  logic                   full_q, full_d;

  logic [drt_pkg::ScreenDimW-1:0] sw_eff, sh_eff;
  logic signed [BoxW-1:0] sw_s, sh_s, sw_m1, sh_m1;
  logic signed [BoxW-1:0] x_s, y_s, w_s, h_s;
  logic signed [BoxW-1:0] lo_x, lo_y, hi_x, hi_y;
  logic signed [BoxW-1:0] x1, y1, x2, y2;
  logic                   box_empty, col_empty, row_ok;
  drt_pkg::action_e       act;

  assign act = drt_pkg::action_e'(action_i);

  assign sw_eff = (screen_width_i  > drt_pkg::MaxScreen) ? drt_pkg::MaxScreen : screen_width_i;
  assign sh_eff = (screen_height_i > drt_pkg::MaxScreen) ? drt_pkg::MaxScreen : screen_height_i;
  assign sw_s   = $signed(BoxW'(sw_eff));
  assign sh_s   = $signed(BoxW'(sh_eff));
  assign sw_m1  = sw_s - SOne;
  assign sh_m1  = sh_s - SOne;

  assign x_s = BoxW'(pos_x_i);
  assign y_s = BoxW'(pos_y_i);
  assign w_s = $signed(BoxW'(rect_w_i));
  assign h_s = $signed(BoxW'(rect_h_i));

  // Extent of the mark; the clamped form raises negative corners to zero.
  always_comb begin
    lo_x = x_s;
    lo_y = y_s;
    if (act == drt_pkg::ACT_MARK_CLAMPED) begin
      if (x_s < SZero) lo_x = SZero;
      if (y_s < SZero) lo_y = SZero;
    end
    if (act == drt_pkg::ACT_MARK_PIXEL) begin
      hi_x = lo_x;
      hi_y = lo_y;
    end else begin
      hi_x = lo_x + w_s - SOne;
      hi_y = lo_y + h_s - SOne;
    end
  end

  // Flush window, clipped to the screen.
  assign box_empty = !full_q && (min_x_q > max_x_q);
  assign x1 = (full_q || min_x_q < SZero) ? SZero : min_x_q;
  assign y1 = (full_q || min_y_q < SZero) ? SZero : min_y_q;
  assign x2 = (full_q || max_x_q >= sw_s) ? sw_m1 : max_x_q;
  assign y2 = (full_q || max_y_q >= sh_s) ? sh_m1 : max_y_q;
  assign col_empty = x2 < x1;
  assign row_ok    = y2 >= y1;

  always_comb begin
    min_x_d      = min_x_q;
    min_y_d      = min_y_q;
    max_x_d      = max_x_q;
    max_y_d      = max_y_q;
    full_d       = full_q;
    has_result_o = 1'b0;
    result_o     = '0;
    case (act)
      drt_pkg::ACT_MARK_PIXEL, drt_pkg::ACT_MARK_RECT,
      drt_pkg::ACT_MARK_CLAMPED: begin
        if (!full_q) begin
          if (lo_x < min_x_q) min_x_d = lo_x;
          if (lo_y < min_y_q) min_y_d = lo_y;
          if (hi_x > max_x_q) max_x_d = hi_x;
          if (hi_y > max_y_q) max_y_d = hi_y;
        end
      end
      drt_pkg::ACT_MARK_FULL: begin
        full_d = 1'b1;
      end
      drt_pkg::ACT_FLUSH: begin
        has_result_o = 1'b1;
        if (!box_empty && !col_empty) begin
          if (row_ok) begin
            result_o.region_valid = 1'b1;
            result_o.left         = x1[OW-1:0];
            result_o.top          = y1[OW-1:0];
            result_o.right        = x2[OW-1:0];
            result_o.bottom       = y2[OW-1:0];
          end
          // Start an empty box for the next frame.
          min_x_d = sw_s;
          min_y_d = sh_s;
          max_x_d = -SOne;
          max_y_d = -SOne;
          full_d  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= SZero;
      min_y_q <= SZero;
      max_x_q <= RstMaxX;
      max_y_q <= RstMaxY;
      full_q  <= 1'b1;
    end else if (fire_i) begin
      min_x_q <= min_x_d;
      min_y_q <= min_y_d;
      max_x_q <= max_x_d;
      max_y_q <= max_y_d;
      full_q  <= full_d;
    end
  end

endmodule

// ===== sv/drt_out_reg.sv =====
// ----------------------------------------------------------------------------
// drt_out_reg: result register of the tracker
// Holds one flush report until the downstream side takes it.
// ----------------------------------------------------------------------------
module drt_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  drt_pkg::drt_region_t data_i,
  output logic                 space_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output drt_pkg::drt_region_t data_o
);

  logic                 valid_q, valid_d;
  drt_pkg::drt_region_t data_q;

  // The register can take a new word when empty or when it drains now.
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/dirty_rectangle_tracker.sv =====
// ----------------------------------------------------------------------------
// dirty_rectangle_tracker: bounding box of changed pixels for a display flush
// Input register, box evaluation and result register, one word per cycle unless a flush waits.
// ----------------------------------------------------------------------------
// The tracker takes one word per clock cycle on the slave stream and keeps a
// single bounding box of changed pixels together with a full-redraw flag.
// Mark words grow the box (a pixel, a rectangle, or a rectangle whose
// negative corner is first raised to zero); a mark-full word sets the flag,
// and while it is set all marks are ignored. Each flush word yields exactly
// one result word: the box clipped to the screen (or the whole screen when
// the flag is set) with region_valid high, or all zeros when nothing is to
// be copied. Other words give no result, and action codes five to seven are
// ignored. A word is taken into the input register and evaluated there
// against the box state; a flush result is then registered in the result
// register, which drives the master stream. The sustained rate is one word
// per cycle; a flush waits in the input register only while the result
// register still holds an earlier report that is not taken. Screen width and
// height are written through the configuration channel (index 0 and 1,
// other indexes ignored), which is always ready; sizes above 8192 behave as
// 8192, and they must only be changed while the tracker is idle.
module dirty_rectangle_tracker #(
  parameter int unsigned COORD_BITS = drt_pkg::CoordBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave stream. tdata, from bit 0: action (3), pos_x (COORD_BITS),
  // pos_y (COORD_BITS), rect_w (15), rect_h (15), zero padding.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((2*COORD_BITS+33+7)/8)*8-1:0] s_axis_tdata,
  // Master stream. tdata, from bit 0: region_valid (1), left (13),
  // top (13), right (13), bottom (13), zero padding.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [55:0]                         m_axis_tdata,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [drt_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [drt_pkg::ScreenDimW-1:0]      cfg_data_i
);

  localparam int unsigned RW    = drt_pkg::RectDimW;
  localparam int unsigned PosXL = 3;
  localparam int unsigned PosYL = PosXL + COORD_BITS;
  localparam int unsigned RectWL = PosYL + COORD_BITS;
  localparam int unsigned RectHL = RectWL + RW;

  // Configuration registers.
  logic [drt_pkg::ScreenDimW-1:0] screen_width_q, screen_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= drt_pkg::DefWidth;
      screen_height_q <= drt_pkg::DefHeight;
    end else if (cfg_valid_i) begin
      case (drt_pkg::cfg_reg_e'(cfg_index_i))
        drt_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        drt_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register. It is refilled in the same cycle in which its word is
  // evaluated, so back-to-back words flow without a bubble.
  logic                          in_valid_q;
  logic [2:0]                    action_q;
  logic signed [COORD_BITS-1:0]  pos_x_q, pos_y_q;
  logic [RW-1:0]                 rect_w_q, rect_h_q;
  logic                          fire, has_result, out_space;
  logic                          s_take;
  drt_pkg::drt_region_t          result, out_data;

  // A non-flush word never waits; a flush waits for room in the result
  // register.
  assign fire          = in_valid_q && (!has_result || out_space);
  assign s_axis_tready = !in_valid_q || fire;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      action_q <= s_axis_tdata[2:0];
      pos_x_q  <= $signed(s_axis_tdata[PosXL +: COORD_BITS]);
      pos_y_q  <= $signed(s_axis_tdata[PosYL +: COORD_BITS]);
      rect_w_q <= s_axis_tdata[RectWL +: RW];
      rect_h_q <= s_axis_tdata[RectHL +: RW];
    end
  end

  drt_box #(
    .COORD_BITS(COORD_BITS)
  ) u_box (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .action_i       (action_q),
    .pos_x_i        (pos_x_q),
    .pos_y_i        (pos_y_q),
    .rect_w_i       (rect_w_q),
    .rect_h_i       (rect_h_q),
    .screen_width_i (screen_width_q),
    .screen_height_i(screen_height_q),
    .has_result_o   (has_result),
    .result_o       (result)
  );

  drt_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire && has_result),
    .data_i (result),
    .space_o(out_space),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (out_data)
  );

  assign m_axis_tdata = {3'b000, out_data.bottom, out_data.right, out_data.top,
                         out_data.left, out_data.region_valid};

`ifndef SYNTHESIS
  // A reported region lies inside the configured screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_data.region_valid) |->
      (14'(out_data.right) < screen_width_q && 14'(out_data.bottom) < screen_height_q
       && out_data.left <= out_data.right && out_data.top <= out_data.bottom))
    else $error("reported region outside the screen or inverted");

  // A flush held behind a stalled result must block the slave side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && has_result && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("slave side ready while a flush is blocked");

  // An evaluated flush is presented on the master side in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && has_result) |=> m_axis_tvalid)
    else $error("flush evaluated without a result word");
`endif

endmodule
